FILE: sv/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared constants, types and register indexes for the wildcard byte
// signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int OFFSET_BITS = 32;
  localparam int SIG_BYTES   = 32;
  localparam int SIG_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int MASK_W      = 32;
  localparam int LENREG_W    = 6;
  localparam int MATCH_W     = 32;
  localparam int REG_IDX_W   = 3;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int TAP_W       = $clog2(MAX_PATTERN);

  localparam logic [REG_IDX_W-1:0] REG_PATTERN0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CARE     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEN      = 3'd5;

  localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [SIG_BYTES-1:0][7:0] sig;
    logic [SIG_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
  } sig_cfg_t;

  typedef struct packed {
    logic                   hit;
    logic                   last;
    logic [OFFSET_BITS-1:0] offset;
  } qent_t;

endpackage

FILE: sv/wbss_if.sv
// ----------------------------------------------------------------------------
// wbss interfaces
// Valid/ready channels: input bytes, scan results and register writes.
// ----------------------------------------------------------------------------
interface wbss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface wbss_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;
  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

interface wbss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/wildcard_byte_signature_scan_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_top
// Finds the first start offset of a wildcard byte signature in a byte stream.
// ----------------------------------------------------------------------------
// Takes one image byte per clock, sustained, as long as results are drained;
// the full signature compare against the byte window is combinational in
// the front stage. The result word for a byte goes from the compare through
// the queue into the output register. At most one result per image: found
// with the start offset on the first match, or not found on the last byte.
// Program the signature registers only while no image is in flight.
module wildcard_byte_signature_scan_top
  import wbss_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  wbss_byte_if.sink     bytes,
  wbss_result_if.source results,
  wbss_cfg_if.sink      cfg
);

  logic [SIG_WORDS-1:0][WORD_W-1:0] pattern_word;
  logic [MASK_W-1:0]                care_mask;
  logic [LENREG_W-1:0]              pattern_len;
  sig_cfg_t                         sig_cfg;
  logic                             push;
  logic                             push_ready;
  qent_t                            push_ent;
  logic                             pop;
  logic                             pop_valid;
  qent_t                            pop_ent;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word <= '0;
      care_mask    <= '0;
      pattern_len  <= LENREG_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_PATTERN0: pattern_word[0] <= cfg.wdata;
        REG_PATTERN1: pattern_word[1] <= cfg.wdata;
        REG_PATTERN2: pattern_word[2] <= cfg.wdata;
        REG_PATTERN3: pattern_word[3] <= cfg.wdata;
        REG_CARE:     care_mask <= cfg.wdata[MASK_W-1:0];
        REG_LEN:      pattern_len <= cfg.wdata[LENREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sig_cfg.sig  = pattern_word;
    sig_cfg.care = care_mask;
    if (pattern_len == '0) begin
      sig_cfg.len = LEN_W'(1);
    end else if (32'(pattern_len) > 32'(MAX_PATTERN)) begin
      sig_cfg.len = LEN_W'(MAX_PATTERN);
    end else begin
      sig_cfg.len = LEN_W'(pattern_len);
    end
  end

  wbss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .cfg        (sig_cfg),
    .push       (push),
    .push_ent   (push_ent),
    .push_ready (push_ready)
  );

  wbss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ent    (pop_ent),
    .pop_valid  (pop_valid)
  );

  wbss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ent   (pop_ent),
    .pop       (pop),
    .results   (results)
  );

endmodule

FILE: sv/wbss_front.sv
// ----------------------------------------------------------------------------
// wbss_front
// Byte window, saturating byte counter and parallel signature compare.
// Pushes one classified word per accepted byte.
// ----------------------------------------------------------------------------
module wbss_front
  import wbss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  wbss_byte_if.sink bytes,
  input  sig_cfg_t  cfg,
  output logic      push,
  output qent_t     push_ent,
  input  logic      push_ready
);

  logic [WIN_DEPTH-1:0][7:0]   win;
  logic [OFFSET_BITS-1:0]      cnt;
  logic [OFFSET_BITS-1:0]      cnt_next;
  logic [MAX_PATTERN-1:0][7:0] taps;
  logic [MAX_PATTERN-1:0]      byte_ok;
  logic [LEN_W-1:0]            tap_sel;
  logic                        accept;

  assign bytes.ready = push_ready;
  assign accept      = bytes.valid && push_ready;
  assign cnt_next    = (cnt == CNT_MAX) ? cnt : cnt + OFFSET_BITS'(1);
  assign taps        = {win, bytes.data_byte};

  always_comb begin
    byte_ok = '1;
    tap_sel = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tap_sel = cfg.len - LEN_W'(1) - LEN_W'(k);
      if (k < SIG_BYTES && LEN_W'(k) < cfg.len) begin
        if (cfg.care[k] && cfg.sig[k] != taps[tap_sel[TAP_W-1:0]]) begin
          byte_ok[k] = 1'b0;
        end
      end
    end
  end

  assign push            = accept;
  assign push_ent.hit    = (cnt_next >= OFFSET_BITS'(cfg.len)) && (&byte_ok);
  assign push_ent.last   = bytes.last_byte;
  assign push_ent.offset = cnt_next - OFFSET_BITS'(cfg.len);

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      cnt <= '0;
    end else if (accept) begin
      if (bytes.last_byte) begin
        win <= '0;
        cnt <= '0;
      end else begin
        win <= {win[WIN_DEPTH-2:0], bytes.data_byte};
        cnt <= cnt_next;
      end
    end
  end

endmodule

FILE: sv/wbss_queue.sv
// ----------------------------------------------------------------------------
// wbss_queue
// Two-word queue between the compare front and the result back end.
// ----------------------------------------------------------------------------
module wbss_queue
  import wbss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_ent,
  output logic  push_ready,
  input  logic  pop,
  output qent_t pop_ent,
  output logic  pop_valid
);

  qent_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_ent    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/wbss_back.sv
// ----------------------------------------------------------------------------
// wbss_back
// Tracks whether the image already matched and loads the result register.
// ----------------------------------------------------------------------------
module wbss_back
  import wbss_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  qent_t         pop_ent,
  output logic          pop,
  wbss_result_if.source results
);

  logic out_valid;
  logic match_seen;
  logic emit;

  assign pop           = pop_valid && (!out_valid || results.ready);
  assign emit          = !match_seen && (pop_ent.hit || pop_ent.last);
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      match_seen <= 1'b0;
    end else begin
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (pop_ent.last) begin
          match_seen <= 1'b0;
        end else if (pop_ent.hit) begin
          match_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      results.found        <= pop_ent.hit;
      results.match_offset <= pop_ent.hit ? MATCH_W'(pop_ent.offset) : '0;
    end
  end

endmodule

FILE: tb/tb_wildcard_byte_signature_scan_top.sv
// ----------------------------------------------------------------------------
// tb_wildcard_byte_signature_scan_top
// Streams byte images into the signature scanner and checks each result word
// against a cycle-free model of the scan: first start offset of the wildcard
// signature, or not found at the last byte. A short directed part covers
// reset defaults, full-care and wildcard signatures, short images, a match
// on the last byte and a zero length. Then random phases reprogram every
// register and send mostly planted images, plus broken plants and noise,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_signature_scan_top;
  import wbss_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst;

  wbss_byte_if   byte_ch ();
  wbss_result_if result_ch ();
  wbss_cfg_if    cfg_ch ();

  wildcard_byte_signature_scan_top uut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  always #2 clk = ~clk;

  // scan model: configuration and per-image state
  logic [WORD_W-1:0] sig_words [SIG_WORDS] = '{default: '0};
  logic [MASK_W-1:0] sig_care = '0;
  logic [5:0]        sig_len_reg = 6'd1;
  logic [7:0]        hist [WIN_DEPTH] = '{default: '0};
  logic [31:0]       img_count = '0;
  bit                img_matched = 1'b0;

  scan_result_t results_due [$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  images_sent = 0;
  int  results_seen = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  function automatic int eff_len();
    int n;
    n = sig_len_reg;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic bit cared(int k);
    return (k < SIG_BYTES) && sig_care[k];
  endfunction

  function automatic logic [7:0] sig_byte(int k);
    if (k >= SIG_BYTES) return 8'($urandom);
    return sig_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic void clear_image_state();
    hist = '{default: '0};
    img_count = '0;
    img_matched = 1'b0;
  endfunction

  function automatic void predict_scan_byte(logic [7:0] b, bit last);
    logic [31:0]  c;
    logic [7:0]   w;
    int           n;
    bit           hit;
    scan_result_t r;
    if (!img_matched) begin
      c = img_count;
      if (c != CNT_MAX) c = c + 1;
      n = eff_len();
      hit = (c >= 32'(n));
      for (int k = 0; k < n; k++) begin
        w = (n - 1 - k == 0) ? b : hist[n - 2 - k];
        if (cared(k) && sig_byte(k) != w) hit = 1'b0;
      end
      for (int i = WIN_DEPTH - 1; i >= 1; i--) hist[i] = hist[i - 1];
      hist[0] = b;
      img_count = c;
      if (hit) begin
        img_matched = 1'b1;
        r.found = 1'b1;
        r.offset = c - 32'(n);
        results_due.push_back(r);
      end else if (last) begin
        r = '0;
        results_due.push_back(r);
      end
    end
    if (last) clear_image_state();
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_result(logic found, logic [31:0] offset);
    scan_result_t e;
    results_seen++;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word found=%0b offset=%0d", found, offset));
    end else begin
      e = results_due.pop_front();
      if (found !== e.found)
        report_mismatch($sformatf("found %0b, want %0b", found, e.found));
      if (offset !== e.offset)
        report_mismatch($sformatf("match_offset %0d, want %0d", offset, e.offset));
    end
  endtask

  // result sink: random stalls, checks every accepted word
  initial begin : result_sink
    int hold;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        check_result(result_ch.found, result_ch.match_offset);
        hold = gaps_on ? $urandom_range(0, 9) : 0;
      end else if (hold == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9);
      end
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d words still due", results_due.size());
      $display("FAIL wildcard_byte_signature_scan_top");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    predict_scan_byte(b, last);
    bytes_sent++;
    if (last) images_sent++;
  endtask

  task automatic send_image(logic [7:0] img [$]);
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all six registers; upper bits beyond each register are random
  task automatic program_sig(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3, logic [31:0] care, logic [5:0] len);
    logic [63:0]          vals [6];
    logic [REG_IDX_W-1:0] idx [6];
    vals[0] = w0;
    vals[1] = w1;
    vals[2] = w2;
    vals[3] = w3;
    vals[4] = {32'($urandom), care};
    vals[5] = {58'({$urandom, $urandom}), len};
    idx[0] = REG_PATTERN0;
    idx[1] = REG_PATTERN1;
    idx[2] = REG_PATTERN2;
    idx[3] = REG_PATTERN3;
    idx[4] = REG_CARE;
    idx[5] = REG_LEN;
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.reg_index <= idx[i];
      cfg_ch.wdata <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        REG_PATTERN0, REG_PATTERN1, REG_PATTERN2, REG_PATTERN3: begin
          sig_words[idx[i]] = vals[i];
        end
        REG_CARE: begin
          sig_care = vals[i][MASK_W-1:0];
        end
        REG_LEN: begin
          sig_len_reg = vals[i][5:0];
        end
        default: begin
        end
      endcase
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_defaults();
    logic [7:0] img [$];
    // length 1, all wildcards: every image matches at its first byte
    img = '{8'h5A};
    send_image(img);
    img = '{8'h00, 8'hFF};
    send_image(img);
    wait_idle();
  endtask

  task automatic test_full_care_matches();
    logic [7:0] img [$];
    program_sig({40'($urandom), 24'h80FF00}, rand64(), rand64(), rand64(),
                32'h0000_0007, 6'd3);
    img = '{8'h00, 8'hFF, 8'h80, 8'h11};
    send_image(img);
    // shorter than the signature
    img = '{8'h00, 8'hFF};
    send_image(img);
    // signature ends on the last byte
    img = '{8'h12, 8'h00, 8'hFF, 8'h80};
    send_image(img);
    img = '{8'h01, 8'h02, 8'h03};
    send_image(img);
    wait_idle();
  endtask

  task automatic test_wildcard_bytes();
    logic [7:0] img [$];
    program_sig({40'($urandom), 8'h55, 8'($urandom), 8'hAA}, rand64(), rand64(), rand64(),
                32'h0000_0005, 6'd3);
    img = '{8'hAA, 8'h37, 8'h55};
    send_image(img);
    img = '{8'h7F, 8'hAA, 8'h00, 8'h55};
    send_image(img);
    wait_idle();
  endtask

  task automatic test_zero_length();
    logic [7:0] img [$];
    program_sig({56'({$urandom, $urandom}), 8'hC3}, rand64(), rand64(), rand64(),
                32'h0000_0001, 6'd0);
    img = '{8'h01, 8'hC3};
    send_image(img);
    wait_idle();
  endtask

  task automatic program_random_sig();
    logic [31:0] care;
    logic [5:0]  len;
    case ($urandom_range(0, 15))
      0:       len = 6'd0;
      1:       len = 6'd32;
      2:       len = 6'($urandom_range(33, 63));
      3:       len = 6'($urandom_range(9, 31));
      default: len = 6'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0:       care = '1;
      1:       care = '0;
      2, 3:    care = $urandom & $urandom;
      default: care = $urandom;
    endcase
    program_sig(rand64(), rand64(), rand64(), rand64(), care, len);
  endtask

  // mostly planted signatures with random wildcard content; some broken
  // plants and some plain noise, including images shorter than the signature
  task automatic send_random_image();
    logic [7:0] img [$];
    int n, ilen, mode, p, k, i;
    bit narrow;
    n = eff_len();
    mode = $urandom_range(0, 9);
    narrow = $urandom_range(0, 1);
    if (mode >= 8) ilen = $urandom_range(1, n + 8);
    else ilen = n + $urandom_range(0, 12);
    for (i = 0; i < ilen; i++) begin
      if (narrow && $urandom_range(0, 2) != 0) img.push_back(sig_byte($urandom_range(0, n - 1)));
      else img.push_back(8'($urandom));
    end
    if (mode < 8) begin
      p = $urandom_range(0, ilen - n);
      for (k = 0; k < n; k++) img[p + k] = cared(k) ? sig_byte(k) : 8'($urandom);
      if (mode == 7) begin
        for (i = 0; i < 8; i++) begin
          k = $urandom_range(0, n - 1);
          if (cared(k)) begin
            img[p + k] = img[p + k] ^ 8'($urandom_range(1, 255));
            break;
          end
        end
      end
    end
    send_image(img);
  endtask

  task automatic test_random_images();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 800) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      program_random_sig();
      repeat ($urandom_range(3, 6)) send_random_image();
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_PATTERN0;
    cfg_ch.wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_full_care_matches();
    test_wildcard_bytes();
    test_zero_length();
    test_random_images();

    wait_idle();
    $display("scanned %0d bytes in %0d images under %0d register settings",
             bytes_sent, images_sent, settings_used);
    $display("checked %0d result words, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("PASS wildcard_byte_signature_scan_top");
    end else begin
      $display("FAIL wildcard_byte_signature_scan_top");
    end
    $finish;
  end

endmodule
